FILE: hw/rtl/ckv_pkg.sv
// Shared widths, request and status codes, and cell control type for the key/value table.
`default_nettype none

package ckv_pkg;

  localparam int unsigned CAPACITY = 128;
  localparam int unsigned CAP_LOG  = $clog2(CAPACITY);
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned VALUE_W  = 40;
  localparam int unsigned INDEX_W  = 7;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD    = 2'd0,
    REQ_SEARCH = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_READ   = 2'd3
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE = 2'd0,
    STAT_FULL = 2'd1,
    STAT_MISS = 2'd2
  } status_e;

  typedef struct packed {
    logic load;   // take the word from the request
    logic shift;  // take the word from the next cell up
  } cell_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/compacting_key_value_table.sv
// Top level of the compacting key/value table: request FSM, entry count, cell row, result register.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------------------
//  in      | sink      | in_valid_i / in_ready_o  | req_type_i key_in_i value_in_i read_index_i
//  out     | source    | out_valid_o / out_ready_i| status_o key_out_o value_out_o entry_count_o
//
// A request runs in two steps: at the accept edge every cell registers its key compare;
// then in ST_EXEC, once the output register is free, the first match is resolved over the row, entries move down one
// cell on a delete, and the result word is loaded into the output register.
// A new request is taken as soon as the previous one has reached the output register.
// While the output register is full and not taken, the ST_EXEC step waits.
// Reset clears the count and control state; the entry registers are not cleared.
`default_nettype none

module compacting_key_value_table (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [ckv_pkg::REQ_W-1:0]      req_type_i,
  input  logic [ckv_pkg::KEY_W-1:0]      key_in_i,
  input  logic [ckv_pkg::VALUE_W-1:0]    value_in_i,
  input  logic [ckv_pkg::INDEX_W-1:0]    read_index_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ckv_pkg::STATUS_W-1:0]   status_o,
  output logic [ckv_pkg::KEY_W-1:0]      key_out_o,
  output logic [ckv_pkg::VALUE_W-1:0]    value_out_o,
  output logic [ckv_pkg::COUNT_W-1:0]    entry_count_o
);
  import ckv_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e               state_q;
  req_e                 req_q;
  logic [KEY_W-1:0]     key_q;
  logic [VALUE_W-1:0]   value_q;
  logic [INDEX_W-1:0]   index_q;
  logic [COUNT_W-1:0]   count_q;
  logic [COUNT_W-1:0]   count_d;

  logic                 out_valid_q;
  status_e              status_q;
  status_e              status_d;
  logic [KEY_W-1:0]     key_out_q;
  logic [VALUE_W-1:0]   value_out_q;

  logic                 accept;
  logic                 exec_go;
  logic                 full;

  logic [CAPACITY-1:0]                cell_match;
  logic [CAPACITY-1:0]                live;
  logic [CAPACITY-1:0]                match_live;
  logic [CAPACITY-1:0]                read_oh;
  logic [CAPACITY-1:0]                seen;
  logic [CAPACITY-1:0][KEY_W-1:0]     cell_key;
  logic [CAPACITY-1:0][VALUE_W-1:0]   cell_value;
  cell_ctl_t [CAPACITY-1:0]           cell_ctl;
  logic                               hit;
  logic [KEY_W-1:0]                   pick_key;
  logic [VALUE_W-1:0]                 pick_value;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign exec_go    = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);
  assign full       = (count_q == COUNT_W'(CAPACITY));

  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    logic [KEY_W-1:0]   nkey;
    logic [VALUE_W-1:0] nval;

    if (j == CAPACITY - 1) begin : g_top
      assign nkey = '0;
      assign nval = '0;
    end else begin : g_mid
      assign nkey = cell_key[j+1];
      assign nval = cell_value[j+1];
    end

    assign live[j]          = (COUNT_W'(j) < count_q);
    assign match_live[j]    = cell_match[j] && live[j];
    assign read_oh[j]       = (index_q == INDEX_W'(j)) && live[j];
    assign cell_ctl[j].load = exec_go && (req_q == REQ_ADD) && !full
                              && (count_q == COUNT_W'(j));
    assign cell_ctl[j].shift = exec_go && (req_q == REQ_DELETE) && seen[j];

    ckv_cell u_cell (
      .clk_i        (clk_i),
      .cmp_en_i     (accept),
      .cmp_key_i    (key_in_i),
      .ctl_i        (cell_ctl[j]),
      .load_key_i   (key_q),
      .load_value_i (value_q),
      .next_key_i   (nkey),
      .next_value_i (nval),
      .key_o        (cell_key[j]),
      .value_o      (cell_value[j]),
      .match_o      (cell_match[j])
    );
  end

  ckv_pick u_pick (
    .match_i    (match_live),
    .use_read_i (req_q == REQ_READ),
    .read_oh_i  (read_oh),
    .keys_i     (cell_key),
    .values_i   (cell_value),
    .seen_o     (seen),
    .hit_o      (hit),
    .key_o      (pick_key),
    .value_o    (pick_value)
  );

  always_comb begin
    count_d  = count_q;
    status_d = STAT_DONE;
    unique case (req_q)
      REQ_ADD: begin
        if (full) begin
          status_d = STAT_FULL;
        end else begin
          count_d = count_q + COUNT_W'(1);
        end
      end
      REQ_DELETE: begin
        if (hit) begin
          count_d = count_q - COUNT_W'(1);
        end else begin
          status_d = STAT_MISS;
        end
      end
      default: begin
        if (!hit) begin
          status_d = STAT_MISS;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (exec_go) begin
            state_q     <= ST_IDLE;
            count_q     <= count_d;
            out_valid_q <= 1'b1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Request and result words carry no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q   <= req_e'(req_type_i);
      key_q   <= key_in_i;
      value_q <= value_in_i;
      index_q <= read_index_i;
    end
    if (exec_go) begin
      status_q    <= status_d;
      // an add returns no entry data
      key_out_q   <= (req_q == REQ_ADD) ? '0 : pick_key;
      value_out_q <= (req_q == REQ_ADD) ? '0 : pick_value;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign key_out_o     = key_out_q;
  assign value_out_o   = value_out_q;
  assign entry_count_o = count_q;

endmodule

`default_nettype wire

FILE: hw/rtl/ckv_cell.sv
// One table entry: key and value registers, key compare flag, shift from its upper neighbor.
`default_nettype none

module ckv_cell (
  input  logic                         clk_i,
  input  logic                         cmp_en_i,
  input  logic [ckv_pkg::KEY_W-1:0]    cmp_key_i,
  input  ckv_pkg::cell_ctl_t           ctl_i,
  input  logic [ckv_pkg::KEY_W-1:0]    load_key_i,
  input  logic [ckv_pkg::VALUE_W-1:0]  load_value_i,
  input  logic [ckv_pkg::KEY_W-1:0]    next_key_i,
  input  logic [ckv_pkg::VALUE_W-1:0]  next_value_i,
  output logic [ckv_pkg::KEY_W-1:0]    key_o,
  output logic [ckv_pkg::VALUE_W-1:0]  value_o,
  output logic                         match_o
);
  import ckv_pkg::*;

  logic [KEY_W-1:0]   key_q;
  logic [VALUE_W-1:0] value_q;
  logic               match_q;

  always_ff @(posedge clk_i) begin
    if (cmp_en_i) begin
      match_q <= (key_q == cmp_key_i);
    end
    if (ctl_i.load) begin
      key_q   <= load_key_i;
      value_q <= load_value_i;
    end else if (ctl_i.shift) begin
      key_q   <= next_key_i;
      value_q <= next_value_i;
    end
  end

  assign key_o   = key_q;
  assign value_o = value_q;
  assign match_o = match_q;

endmodule

`default_nettype wire

FILE: hw/rtl/ckv_pick.sv
// First-match resolve across the cell row and one-hot selection of the chosen entry.
`default_nettype none

module ckv_pick (
  input  logic [ckv_pkg::CAPACITY-1:0]                      match_i,
  input  logic                                              use_read_i,
  input  logic [ckv_pkg::CAPACITY-1:0]                      read_oh_i,
  input  logic [ckv_pkg::CAPACITY-1:0][ckv_pkg::KEY_W-1:0]   keys_i,
  input  logic [ckv_pkg::CAPACITY-1:0][ckv_pkg::VALUE_W-1:0] values_i,
  output logic [ckv_pkg::CAPACITY-1:0]                      seen_o,
  output logic                                              hit_o,
  output logic [ckv_pkg::KEY_W-1:0]                         key_o,
  output logic [ckv_pkg::VALUE_W-1:0]                       value_o
);
  import ckv_pkg::*;

  logic [CAP_LOG:0][CAPACITY-1:0] pre;
  logic [CAPACITY-1:0]            first_oh;
  logic [CAPACITY-1:0]            sel;

  // Log-depth prefix OR: seen[j] is set when some cell at or below j matched.
  always_comb begin
    pre[0] = match_i;
    for (int l = 0; l < CAP_LOG; l++) begin
      for (int j = 0; j < CAPACITY; j++) begin
        if (j >= (1 << l)) begin
          pre[l+1][j] = pre[l][j] | pre[l][j - (1 << l)];
        end else begin
          pre[l+1][j] = pre[l][j];
        end
      end
    end
  end

  assign seen_o   = pre[CAP_LOG];
  assign first_oh = seen_o & ~{seen_o[CAPACITY-2:0], 1'b0};
  assign sel      = use_read_i ? read_oh_i : first_oh;
  assign hit_o    = use_read_i ? (|read_oh_i) : seen_o[CAPACITY-1];

  always_comb begin
    key_o   = '0;
    value_o = '0;
    for (int j = 0; j < CAPACITY; j++) begin
      key_o   = key_o | (keys_i[j] & {KEY_W{sel[j]}});
      value_o = value_o | (values_i[j] & {VALUE_W{sel[j]}});
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ckv_checker.sv
// Port-level checks for the key/value table, bound to its top level.
`default_nettype none

module ckv_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [ckv_pkg::STATUS_W-1:0]   status_o,
  input logic [ckv_pkg::KEY_W-1:0]      key_out_o,
  input logic [ckv_pkg::VALUE_W-1:0]    value_out_o,
  input logic [ckv_pkg::COUNT_W-1:0]    entry_count_o
);
  import ckv_pkg::*;

  // Hold a stalled result word.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(key_out_o) && $stable(value_out_o) && $stable(entry_count_o))
    else $error("result word changed while stalled");

  // Drop ready for the cycle after a request is taken.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken on back-to-back cycles");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STAT_FULL) |->
      (entry_count_o == COUNT_W'(CAPACITY)) && (key_out_o == '0) && (value_out_o == '0))
    else $error("full status with wrong count or nonzero data");

  a_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STAT_MISS) |-> (key_out_o == '0) && (value_out_o == '0))
    else $error("miss status with nonzero data");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (entry_count_o <= COUNT_W'(CAPACITY))
      && ((status_o == STAT_DONE) || (status_o == STAT_FULL) || (status_o == STAT_MISS)))
    else $error("count beyond capacity or bad status code");

endmodule

bind compacting_key_value_table ckv_checker u_ckv_checker (.*);

`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for compacting_key_value_table: request stimulus, predictor, checks.
module tb;
  import ckv_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int TIMEOUT_CYCLES = 400000;

  typedef struct packed {
    status_e              status;
    logic [KEY_W-1:0]     key;
    logic [VALUE_W-1:0]   value;
    logic [COUNT_W-1:0]   count;
  } table_result_t;

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                in_valid_i   = 1'b0;
  logic                in_ready_o;
  logic [REQ_W-1:0]    req_type_i   = '0;
  logic [KEY_W-1:0]    key_in_i     = '0;
  logic [VALUE_W-1:0]  value_in_i   = '0;
  logic [INDEX_W-1:0]  read_index_i = '0;
  logic                out_valid_o;
  logic                out_ready_i  = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [KEY_W-1:0]    key_out_o;
  logic [VALUE_W-1:0]  value_out_o;
  logic [COUNT_W-1:0]  entry_count_o;

  // Predicted contents of the table
  logic [KEY_W-1:0]   stored_keys [CAPACITY];
  logic [VALUE_W-1:0] stored_values [CAPACITY];
  int unsigned        stored_count = 0;

  table_result_t pending_results[$];

  logic steady_flow    = 1'b0;
  int   mismatch_count = 0;
  int   n_adds = 0, n_full = 0, n_searches = 0, n_deletes = 0, n_reads = 0;
  int   n_misses = 0, n_checked = 0;
  int unsigned peak_count = 0;

  compacting_key_value_table dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .key_in_i     (key_in_i),
    .value_in_i   (value_in_i),
    .read_index_i (read_index_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .key_out_o    (key_out_o),
    .value_out_o  (value_out_o),
    .entry_count_o(entry_count_o)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("%0t: timeout, %0d results still pending", $time, pending_results.size());
    $display("[compacting_key_value_table] ERROR");
    $finish;
  end

  // Work out the result of one accepted request and update the predicted table.
  task automatic apply_request(input req_e req, input logic [KEY_W-1:0] key,
                               input logic [VALUE_W-1:0] value,
                               input logic [INDEX_W-1:0] index);
    table_result_t res;
    int            hit_pos;
    res.status = STAT_DONE;
    res.key    = '0;
    res.value  = '0;
    hit_pos    = -1;
    case (req)
      REQ_ADD: begin
        n_adds++;
        if (stored_count >= CAPACITY) begin
          res.status = STAT_FULL;
          n_full++;
        end else begin
          stored_keys[stored_count]   = key;
          stored_values[stored_count] = value;
          stored_count++;
        end
      end
      REQ_SEARCH, REQ_DELETE: begin
        if (req == REQ_SEARCH) n_searches++;
        else n_deletes++;
        for (int i = 0; i < stored_count; i++) begin
          if (hit_pos < 0 && stored_keys[i] == key) hit_pos = i;
        end
        if (hit_pos < 0) begin
          res.status = STAT_MISS;
        end else begin
          res.key   = stored_keys[hit_pos];
          res.value = stored_values[hit_pos];
          if (req == REQ_DELETE) begin
            // close the gap, keep order
            for (int j = hit_pos; j + 1 < stored_count; j++) begin
              stored_keys[j]   = stored_keys[j + 1];
              stored_values[j] = stored_values[j + 1];
            end
            stored_count--;
          end
        end
      end
      default: begin
        n_reads++;
        if (index < stored_count) begin
          res.key   = stored_keys[index];
          res.value = stored_values[index];
        end else begin
          res.status = STAT_MISS;
        end
      end
    endcase
    if (res.status == STAT_MISS) n_misses++;
    if (stored_count > peak_count) peak_count = stored_count;
    res.count = stored_count[COUNT_W-1:0];
    pending_results.push_back(res);
  endtask

  // Present one request word and hold it until accepted.
  task automatic send_request(input req_e req, input logic [KEY_W-1:0] key,
                              input logic [VALUE_W-1:0] value,
                              input logic [INDEX_W-1:0] index);
    @(negedge clk_i);
    while (!steady_flow && $urandom_range(0, 99) < 25) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= req;
    key_in_i     <= key;
    value_in_i   <= value;
    read_index_i <= index;
    do @(posedge clk_i); while (!in_ready_o);
    apply_request(req, key, value, index);
  endtask

  // Drop valid and wait until every pending result has come back.
  task automatic hold_off();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending_results.size() == 0);
  endtask

  function automatic logic [KEY_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [VALUE_W-1:0] rand_value();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return bits[VALUE_W-1:0];
  endfunction

  // A stored key with a chance of hit_pct percent, else a random key.
  function automatic logic [KEY_W-1:0] pick_key(input int unsigned hit_pct);
    if (stored_count != 0 && $urandom_range(0, 99) < hit_pct)
      return stored_keys[$urandom_range(0, stored_count - 1)];
    return rand_key();
  endfunction

  function automatic logic [INDEX_W-1:0] pick_index();
    int unsigned idx;
    if (stored_count != 0 && $urandom_range(0, 1) == 1) idx = $urandom_range(0, stored_count - 1);
    else idx = $urandom_range(0, CAPACITY - 1);
    return idx[INDEX_W-1:0];
  endfunction

  task automatic report_mismatch(input string field, input logic [KEY_W-1:0] expected,
                                 input logic [KEY_W-1:0] actual);
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, expected, actual);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin : result_check
    table_result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, status %h key %h value %h count %h", $time,
                 status_o, key_out_o, value_out_o, entry_count_o);
        mismatch_count++;
      end else begin
        exp_res = pending_results.pop_front();
        n_checked++;
        if (status_o !== exp_res.status) report_mismatch("status", exp_res.status, status_o);
        if (key_out_o !== exp_res.key) report_mismatch("key_out", exp_res.key, key_out_o);
        if (value_out_o !== exp_res.value)
          report_mismatch("value_out", exp_res.value, value_out_o);
        if (entry_count_o !== exp_res.count)
          report_mismatch("entry_count", exp_res.count, entry_count_o);
      end
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= steady_flow || ($urandom_range(0, 99) >= 25);
  end

  task automatic test_directed();
    logic [KEY_W-1:0] name_key;
    name_key = {"alice", 24'h0};
    // empty table: every lookup misses
    send_request(REQ_SEARCH, '0, '0, '0);
    send_request(REQ_DELETE, '1, '1, '1);
    send_request(REQ_READ, '0, '0, '0);
    send_request(REQ_READ, '1, '1, '1);
    send_request(REQ_ADD, '1, '1, '0);
    send_request(REQ_ADD, '0, '0, '1);
    send_request(REQ_ADD, name_key, 40'h55_5123_4567, '0);
    send_request(REQ_ADD, '1, 40'h01_2345_6789, '0);
    // duplicate key: first one wins
    send_request(REQ_SEARCH, '1, '0, '0);
    send_request(REQ_SEARCH, '0, '1, '1);
    send_request(REQ_SEARCH, name_key ^ 64'h1, '0, '0);
    send_request(REQ_READ, '0, '1, 7'd0);
    send_request(REQ_READ, '1, '0, 7'd1);
    send_request(REQ_READ, '0, '0, 7'd2);
    send_request(REQ_READ, '0, '0, 7'd3);
    send_request(REQ_READ, '0, '0, 7'd4);
    send_request(REQ_DELETE, '1, '1, '1);
    send_request(REQ_SEARCH, '1, '0, '0);
    send_request(REQ_READ, '0, '0, 7'd0);
    send_request(REQ_READ, '0, '0, 7'd2);
    send_request(REQ_DELETE, '0, '0, '0);
    send_request(REQ_DELETE, name_key, '0, '0);
    send_request(REQ_DELETE, '1, '0, '0);
    send_request(REQ_READ, '0, '0, 7'd0);
  endtask

  task automatic test_full_table();
    while (stored_count < CAPACITY)
      send_request(REQ_ADD, pick_key(5), rand_value(), pick_index());
    repeat (6) send_request(REQ_ADD, rand_key(), rand_value(), pick_index());
    send_request(REQ_READ, rand_key(), rand_value(), 7'd127);
    send_request(REQ_SEARCH, stored_keys[CAPACITY - 1], rand_value(), pick_index());
    send_request(REQ_SEARCH, rand_key(), rand_value(), pick_index());
    send_request(REQ_DELETE, rand_key(), rand_value(), pick_index());
    send_request(REQ_DELETE, stored_keys[CAPACITY / 2], rand_value(), pick_index());
    send_request(REQ_ADD, rand_key(), rand_value(), pick_index());
    send_request(REQ_ADD, rand_key(), rand_value(), pick_index());
    send_request(REQ_DELETE, stored_keys[0], rand_value(), pick_index());
    send_request(REQ_DELETE, stored_keys[stored_count - 1], rand_value(), pick_index());
    send_request(REQ_READ, rand_key(), rand_value(), 7'd127);
    send_request(REQ_READ, rand_key(), rand_value(), 7'd0);
  endtask

  task automatic test_random_mix(input int n_items, input int unsigned add_pct);
    req_e req;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 99) < add_pct) req = REQ_ADD;
      else req = req_e'($urandom_range(REQ_SEARCH, REQ_READ));
      send_request(req, pick_key(req == REQ_ADD ? 10 : 80), rand_value(), pick_index());
    end
  endtask

  task automatic test_drain_pause();
    repeat (3) begin
      test_random_mix(12, 40);
      hold_off();
    end
  endtask

  task automatic test_steady_stream();
    steady_flow = 1'b1;
    test_random_mix(200, 45);
    steady_flow = 1'b0;
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_full_table();
    test_random_mix(300, 20);
    test_drain_pause();
    test_random_mix(300, 65);
    test_steady_stream();
    test_random_mix(150, 45);
    hold_off();
    repeat (8) @(posedge clk_i);
    $display("checked %0d results: %0d adds (%0d on a full table), %0d searches,", n_checked,
             n_adds, n_full, n_searches);
    $display("%0d deletes, %0d reads, %0d misses; peak occupancy %0d of %0d", n_deletes,
             n_reads, n_misses, peak_count, CAPACITY);
    if (mismatch_count == 0) begin
      $display("[compacting_key_value_table] OK");
    end else begin
      $display("[compacting_key_value_table] ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/ckv_pkg.sv
hw/rtl/ckv_cell.sv
hw/rtl/ckv_pick.sv
hw/rtl/compacting_key_value_table.sv
hw/rtl/ckv_checker.sv
verif/tb.sv
